// ===== src/pdd_pkg.sv =====
// ----------------------------------------------------------------------------
// PNM pixel data decoder package
// Shared constants, result status codes and the queue entry type that joins
// the classifying front end to the sample sequencer.
// ----------------------------------------------------------------------------
package pdd_pkg;

  // Lexer limit on digits in one decimal field.
  localparam int unsigned MAX_DIGITS = 12;
  // Width of the sample counter and of the sample_count register.
  localparam int unsigned COUNT_BITS = 24;

  // Field widths.
  localparam int unsigned VALUE_BITS  = 31;
  localparam int unsigned FORMAT_BITS = 3;
  localparam int unsigned ROW_BITS    = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 24;

  // Queue between front end and sequencer.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_COUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_WIDTH    = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADCHAR = 2'd1,
    ST_TOOLONG = 2'd2,
    ST_SHORT   = 2'd3
  } status_e;

  // One queued job: a single sample, or a byte to be unpacked into
  // cnt_m1 + 1 bit samples, most significant bit first.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    status_e               status;
    logic                  last;
    logic                  unpack;
    logic [2:0]            cnt_m1;
  } entry_t;

endpackage

// ===== src/pdd_fifo.sv =====
// ----------------------------------------------------------------------------
// PNM decoder job queue
// Short register queue that lets the front end and the sequencer stall
// independently of each other.
// ----------------------------------------------------------------------------
module pdd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pdd_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pdd_pkg::entry_t head_o
);
  import pdd_pkg::*;

  entry_t                store_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wptr_q, wptr_d;
  logic [QPTR_BITS-1:0]  rptr_q, rptr_d;
  logic [QPTR_BITS:0]    count_q, count_d;

  assign full_o  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = store_q[rptr_q];

  // Pointer and fill level update.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wptr_q] <= entry_i;
    end
  end

  // The front end never writes into a full queue.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("job queue written while full");

  // The sequencer never takes a job from an empty queue.
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("job queue read while empty");

endmodule

// ===== src/pdd_front.sv =====
// ----------------------------------------------------------------------------
// PNM decoder front end
// Holds the configuration, lexes or classifies each accepted byte, keeps
// the sample and row counters and queues one job per byte that yields
// samples.
// ----------------------------------------------------------------------------
module pdd_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [pdd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [pdd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         in_byte_i,
  input  logic                               in_eos_i,
  output logic                               push_o,
  output pdd_pkg::entry_t                    entry_o,
  input  logic                               full_i
);
  import pdd_pkg::*;

  // Lexer modes.
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_NUMBER  = 2'd1;
  localparam logic [1:0] MODE_COMMENT = 2'd2;

  // Image format numbers.
  localparam logic [FORMAT_BITS-1:0] FMT_BIT_ASCII  = 3'd1;
  localparam logic [FORMAT_BITS-1:0] FMT_GRAY_ASCII = 3'd2;
  localparam logic [FORMAT_BITS-1:0] FMT_RGB_ASCII  = 3'd3;
  localparam logic [FORMAT_BITS-1:0] FMT_BIT_BIN    = 3'd4;
  localparam logic [FORMAT_BITS-1:0] FMT_GRAY_BIN   = 3'd5;
  localparam logic [FORMAT_BITS-1:0] FMT_RGB_BIN    = 3'd6;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  logic [FORMAT_BITS-1:0] fmt_q;
  logic [COUNT_BITS-1:0]  scount_q;
  logic [ROW_BITS-1:0]    rwidth_q;

  logic [1:0]            mode_q, mode_d;
  logic [3:0]            dcnt_q, dcnt_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [COUNT_BITS-1:0] sdone_q, sdone_d;
  logic [ROW_BITS-1:0]   rpos_q, rpos_d;

  logic                  accept;
  logic                  complete;
  logic                  is_digit, is_space, is_hash, is_newline;
  logic [VALUE_BITS-1:0] base_acc;
  logic [3:0]            base_dcnt, dcnt_inc;
  logic [VALUE_BITS+3:0] acc_wide;
  logic [VALUE_BITS-1:0] acc_sat;
  logic                  emit;
  logic [VALUE_BITS-1:0] em_val;
  status_e               em_st;
  logic [3:0]            em_n;
  logic                  em_unpack;
  logic [COUNT_BITS-1:0] count_rem;
  logic [ROW_BITS:0]     row_rem;
  logic [3:0]            cand_n, bits_n;
  logic                  pad_hit;
  logic [COUNT_BITS-1:0] sdone_next;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign complete   = (sdone_q >= scount_q);

  // Byte classes.
  assign is_digit   = (in_byte_i >= 8'h30) && (in_byte_i <= 8'h39);
  assign is_hash    = (in_byte_i == 8'h23);
  assign is_newline = (in_byte_i == 8'h0A);
  assign is_space   = (in_byte_i == 8'h20) || ((in_byte_i >= 8'h09) && (in_byte_i <= 8'h0D));

  // Next decimal accumulator value, saturated; an idle lexer starts from zero.
  assign base_acc  = (mode_q == MODE_NUMBER) ? acc_q : '0;
  assign base_dcnt = (mode_q == MODE_NUMBER) ? dcnt_q : '0;
  assign dcnt_inc  = base_dcnt + 4'd1;
  assign acc_wide  = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1)
                     + {(VALUE_BITS + 4 - 4)'(0), in_byte_i[3:0]};
  assign acc_sat   = (acc_wide > {4'b0, VALUE_MAX}) ? VALUE_MAX : acc_wide[VALUE_BITS-1:0];

  // Packed bit format: samples this byte yields, bounded by row end and count.
  assign count_rem = scount_q - sdone_q;
  always_comb begin
    if (rwidth_q == '0) begin
      row_rem = (ROW_BITS+1)'(8);
    end else if (rpos_q < rwidth_q) begin
      row_rem = {1'b0, rwidth_q} - {1'b0, rpos_q};
    end else if (rpos_q == {ROW_BITS{1'b1}}) begin
      // The position wraps to zero first, so a full row follows.
      row_rem = {1'b0, rwidth_q} + (ROW_BITS+1)'(1);
    end else begin
      row_rem = (ROW_BITS+1)'(1);
    end
    cand_n = (count_rem < COUNT_BITS'(8)) ? count_rem[3:0] : 4'd8;
    bits_n = (row_rem < {{(ROW_BITS-3){1'b0}}, cand_n}) ? row_rem[3:0] : cand_n;
    pad_hit = (rwidth_q != '0) && ({{(ROW_BITS-3){1'b0}}, bits_n} == row_rem);
  end

  // Lexer and classification of the accepted byte.
  always_comb begin
    mode_d    = mode_q;
    dcnt_d    = dcnt_q;
    acc_d     = acc_q;
    sdone_d   = sdone_q;
    rpos_d    = rpos_q;
    emit      = 1'b0;
    em_val    = '0;
    em_st     = ST_OK;
    em_n      = 4'd1;
    em_unpack = 1'b0;
    if (accept) begin
      if (in_eos_i) begin
        emit    = !complete;
        em_st   = ST_SHORT;
        mode_d  = MODE_IDLE;
        dcnt_d  = '0;
        acc_d   = '0;
        rpos_d  = '0;
      end else if (!complete) begin
        unique case (fmt_q)
          FMT_BIT_ASCII: begin
            if (mode_q == MODE_COMMENT) begin
              if (is_newline) begin
                mode_d = MODE_IDLE;
              end
            end else begin
              mode_d = MODE_IDLE;
              dcnt_d = '0;
              acc_d  = '0;
              if ((in_byte_i == 8'h30) || (in_byte_i == 8'h31)) begin
                emit   = 1'b1;
                em_val = {(VALUE_BITS-1)'(0), in_byte_i[0]};
              end else if (is_hash) begin
                mode_d = MODE_COMMENT;
              end else if (!is_space) begin
                emit  = 1'b1;
                em_st = ST_BADCHAR;
              end
            end
          end
          FMT_GRAY_ASCII, FMT_RGB_ASCII: begin
            if (mode_q == MODE_COMMENT) begin
              if (is_newline) begin
                mode_d = MODE_IDLE;
              end
            end else if (is_digit) begin
              if (dcnt_inc >= 4'(MAX_DIGITS)) begin
                emit   = 1'b1;
                em_st  = ST_TOOLONG;
                mode_d = MODE_IDLE;
                dcnt_d = '0;
                acc_d  = '0;
              end else begin
                mode_d = MODE_NUMBER;
                dcnt_d = dcnt_inc;
                acc_d  = acc_sat;
              end
            end else begin
              mode_d = MODE_IDLE;
              dcnt_d = '0;
              acc_d  = '0;
              if (mode_q == MODE_NUMBER) begin
                // A number ends at whitespace; anything else is an error.
                emit   = 1'b1;
                em_val = is_space ? acc_q : '0;
                em_st  = is_space ? ST_OK : ST_BADCHAR;
              end else if (is_hash) begin
                mode_d = MODE_COMMENT;
              end else if (!is_space) begin
                emit  = 1'b1;
                em_st = ST_BADCHAR;
              end
            end
          end
          FMT_BIT_BIN: begin
            emit      = 1'b1;
            em_val    = {(VALUE_BITS-8)'(0), in_byte_i};
            em_n      = bits_n;
            em_unpack = 1'b1;
            rpos_d    = pad_hit ? '0 : rpos_q + {(ROW_BITS-4)'(0), bits_n};
          end
          FMT_GRAY_BIN, FMT_RGB_BIN: begin
            emit   = 1'b1;
            em_val = {(VALUE_BITS-8)'(0), in_byte_i};
          end
          default: begin
          end
        endcase
      end
    end

    // Counted samples advance the sample counter; end of stream clears it.
    sdone_next = sdone_q + {(COUNT_BITS-4)'(0), em_n};
    if (accept && in_eos_i) begin
      sdone_d = '0;
    end else if (emit) begin
      sdone_d = sdone_next;
    end
  end

  assign push_o         = emit;
  assign entry_o.value  = em_val;
  assign entry_o.status = em_st;
  assign entry_o.last   = !in_eos_i && (sdone_next == scount_q);
  assign entry_o.unpack = em_unpack;
  assign entry_o.cnt_m1 = 3'(em_n - 4'd1);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_GRAY_ASCII;
      scount_q <= COUNT_BITS'(1);
      rwidth_q <= ROW_BITS'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_FORMAT: fmt_q    <= cfg_data_i[FORMAT_BITS-1:0];
        REG_SAMPLE_COUNT: scount_q <= cfg_data_i[COUNT_BITS-1:0];
        REG_ROW_WIDTH:    rwidth_q <= cfg_data_i[ROW_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Lexer and counter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      dcnt_q  <= '0;
      acc_q   <= '0;
      sdone_q <= '0;
      rpos_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      dcnt_q  <= dcnt_d;
      acc_q   <= acc_d;
      sdone_q <= sdone_d;
      rpos_q  <= rpos_d;
    end
  end

  // A field that has reached the digit limit has already been reported.
  a_digit_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q < 4'(MAX_DIGITS))
    else $error("digit count reached the limit without a report");

endmodule

// ===== src/pdd_back.sv =====
// ----------------------------------------------------------------------------
// PNM decoder sample sequencer
// Takes queued jobs and presents their samples one per cycle on the result
// channel while it is ready, unpacking bit jobs most significant bit first.
// ----------------------------------------------------------------------------
module pdd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pdd_pkg::entry_t                  head_i,
  input  logic                             empty_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pdd_pkg::VALUE_BITS-1:0]   out_value_o,
  output pdd_pkg::status_e                 out_status_o,
  output logic                             out_last_o
);
  import pdd_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       final_bit;
  logic       take;
  logic [7:0] src_byte;

  assign out_valid_o  = !empty_i;
  assign take         = out_valid_o && out_ready_i;
  assign final_bit    = (idx_q == head_i.cnt_m1);
  assign pop_o        = take && final_bit;
  assign out_status_o = head_i.status;
  assign out_last_o   = head_i.last && final_bit;
  assign src_byte     = head_i.value[7:0];

  // Sample value: the selected bit of a packed byte, or the value itself.
  always_comb begin
    if (head_i.unpack) begin
      out_value_o = {(VALUE_BITS-1)'(0), src_byte[3'd7 - idx_q]};
    end else begin
      out_value_o = head_i.value;
    end
  end

  // Bit index within the current job.
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = final_bit ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // The index never runs past the sample count of the job at the head.
  a_idx_in_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q <= head_i.cnt_m1))
    else $error("bit index beyond the current job");

  // A stalled result keeps its place within the job.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(idx_q))
    else $error("bit index moved during a stall");

  // Only single-sample jobs carry an error status.
  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (head_i.status != ST_OK)) |-> (head_i.cnt_m1 == 3'd0))
    else $error("error job with more than one sample");

endmodule

// ===== src/pnm_pixel_data_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// PNM pixel data decoder
// Decodes the raster bytes of a PNM image into pixel samples.
//
//  Channel  | Dir | Handshake              | Content
//  ---------+-----+------------------------+---------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | raster byte, end of stream
//  m_axis   | out | m_axis_tvalid/tready   | sample value, status, last
//  cfg      | in  | cfg_valid_i/cfg_ready_o| register index and write data
//
// A byte is classified in the cycle it is accepted; a new byte is taken every
// cycle while the four-entry job queue has room. Each job drains at one
// sample per cycle on the result channel while m_axis_tready is high, so a
// packed bit byte holds the sequencer for up to eight samples. Reset clears
// the lexer and counters asynchronously. Either side may stall without
// blocking the other until the queue fills.
// ----------------------------------------------------------------------------
module pnm_pixel_data_decoder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pdd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [pdd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // Raster byte stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] data_byte
  input  logic                               s_axis_tlast,  // end_of_stream
  // Sample stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [31:0]                        m_axis_tdata,  // [30:0] sample_value, [31] zero
  output logic [1:0]                         m_axis_tuser,  // [1:0] status
  output logic                               m_axis_tlast   // last_sample
);
  import pdd_pkg::*;

  entry_t                push_entry;
  entry_t                head;
  logic                  push, full, pop, empty;
  logic [VALUE_BITS-1:0] value;
  status_e               status;

  assign cfg_ready_o = 1'b1;

  // Classifying front end with configuration registers.
  pdd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eos_i    (s_axis_tlast),
    .push_o      (push),
    .entry_o     (push_entry),
    .full_i      (full)
  );

  // Job queue.
  pdd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  // Sample sequencer.
  pdd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (value),
    .out_status_o (status),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, value};
  assign m_axis_tuser = status;

endmodule
